/* rtl/psv_pkg.sv */
// ----------------------------------------------------------------------------
// psv_pkg
// shared types and constants of the point seek pd velocity block
// ----------------------------------------------------------------------------
package psv_pkg;

    // field widths
    localparam int POS_W    = 16;   // positions and targets in mm
    localparam int MAG_W    = 17;   // multiplier operand width
    localparam int PROD_W   = 2 * MAG_W;
    localparam int DIST_W   = 17;   // floor distance
    localparam int SPEED_W  = 13;   // speed, 0..4096
    localparam int VEL_W    = 14;   // signed velocity
    localparam int GAIN_W   = 16;

    // square root unit
    localparam int SQ_IN_W  = 34;   // radicand, even width
    localparam int SQ_REM_W = 20;
    localparam int SQ_STEPS = SQ_IN_W / 2;
    localparam int SQ_CNT_W = 5;

    // divider unit
    localparam int DIV_NUM_W = 29;  // speed * |delta| < 2^29
    localparam int DIV_DEN_W = DIST_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [SPEED_W-1:0] SPEED_CAP = 13'd4096;

    // register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_TARGET_X    = 3'd0,
        REG_TARGET_Y    = 3'd1,
        REG_ARRIVE_THR  = 3'd2,
        REG_PROP_GAIN   = 3'd3,
        REG_DERIV_GAIN  = 3'd4,
        REG_SPEED_LIMIT = 3'd5
    } t_reg_idx;

    // status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;     // one-cycle pulse, result valid
    } t_unit_stat;

endpackage

/* rtl/psv_mul.sv */
// ----------------------------------------------------------------------------
// psv_mul
// shared unsigned 17x17 multiplier with registered product
// ----------------------------------------------------------------------------
module psv_mul (
    input  logic                        i_clk,
    input  logic [psv_pkg::MAG_W-1:0]   i_a,
    input  logic [psv_pkg::MAG_W-1:0]   i_b,
    output logic [psv_pkg::PROD_W-1:0]  o_prod
);
    import psv_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

/* rtl/psv_sqrt.sv */
// ----------------------------------------------------------------------------
// psv_sqrt
// floor square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module psv_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [psv_pkg::SQ_IN_W-1:0]   i_radicand,
    output psv_pkg::t_unit_stat           o_stat,
    output logic [psv_pkg::DIST_W-1:0]    o_root
);
    import psv_pkg::*;

    logic [SQ_IN_W-1:0]  r_rad;
    logic [SQ_REM_W-1:0] r_rem;
    logic [DIST_W-1:0]   r_root;
    logic [SQ_CNT_W-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [SQ_REM_W-1:0] w_rem_sh;
    logic [SQ_REM_W-1:0] w_trial;
    logic                w_fit;

    // shift in the next bit pair, try root*4+1
    assign w_rem_sh = {r_rem[SQ_REM_W-3:0], r_rad[SQ_IN_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad <= {r_rad[SQ_IN_W-3:0], 2'b00};
                if (w_fit) begin
                    r_rem  <= w_rem_sh - w_trial;
                    r_root <= {r_root[DIST_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh;
                    r_root <= {r_root[DIST_W-2:0], 1'b0};
                end
                if (r_cnt == SQ_CNT_W'(SQ_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

endmodule

/* rtl/psv_div.sv */
// ----------------------------------------------------------------------------
// psv_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module psv_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [psv_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [psv_pkg::DIV_DEN_W-1:0]   i_den,
    output psv_pkg::t_unit_stat             o_stat,
    output logic [psv_pkg::DIV_NUM_W-1:0]   o_quot
);
    import psv_pkg::*;

    logic [DIV_NUM_W-1:0] r_q;      // dividend out at the top, quotient in at the bottom
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   w_rem_sh;
    logic                 w_fit;

    assign w_rem_sh = {r_rem, r_q[DIV_NUM_W-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (w_fit) begin
                    r_rem <= DIV_DEN_W'(w_rem_sh - {1'b0, r_den});
                    r_q   <= {r_q[DIV_NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh[DIV_DEN_W-1:0];
                    r_q   <= {r_q[DIV_NUM_W-2:0], 1'b0};
                end
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule

/* rtl/point_seek_pd_velocity.sv */
// sequence: each accepted word runs the 17-step square root; a moving step at
//   nonzero distance adds two 29-step divisions, and the shared multiplier
//   serves every product; no new word is taken until the result is loaded
//   into the output register
// reset: synchronous active low, configuration registers return to their reset values,
//   stored distance and arrived flag cleared, no result pending
// ----------------------------------------------------------------------------
// point_seek_pd_velocity
// go-to-point pd speed controller: distance to target, pd speed, clamp,
// and velocity split along the unit vector toward the target
// ----------------------------------------------------------------------------
module point_seek_pd_velocity (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input word stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // robot_x[15:0], robot_y[31:16]
    input  logic        s_axis_tuser,   // first_of_goal
    // result word stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // vel_x[13:0], vel_y[27:14], distance[44:28], zeros
    output logic        m_axis_tuser    // arrived
);
    import psv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,     // wait for a word
        S_SQX,      // dx^2 into the multiplier
        S_SQY,      // park dx^2, dy^2 into the multiplier
        S_SUM,      // sum of squares, start root
        S_SQRT,     // wait for the root
        S_DEC,      // arrival decision
        S_KP,       // kp * d
        S_KD,       // kd * |d - last|
        S_SPD,      // pd sum, clamp to the limit
        S_MX,       // speed * |dx|
        S_DX,       // start x division
        S_DIVX,     // wait x quotient
        S_MY,       // speed * |dy|
        S_DY,       // start y division
        S_DIVY,     // wait y quotient
        S_OUT       // hand the result to the output register
    } t_state;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic signed [POS_W-1:0]   r_target_x;
    logic signed [POS_W-1:0]   r_target_y;
    logic        [POS_W-1:0]   r_arrive_thr;
    logic        [GAIN_W-1:0]  r_prop_gain;
    logic        [GAIN_W-1:0]  r_deriv_gain;
    logic        [SPEED_W-1:0] r_speed_limit;

    logic     w_cfg_wr;
    t_reg_idx w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x    <= '0;
            r_target_y    <= '0;
            r_arrive_thr  <= 16'd100;
            r_prop_gain   <= 16'd1573;
            r_deriv_gain  <= 16'd315;
            r_speed_limit <= 13'd1024;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_TARGET_X:    r_target_x    <= pwdata[POS_W-1:0];
                REG_TARGET_Y:    r_target_y    <= pwdata[POS_W-1:0];
                REG_ARRIVE_THR:  r_arrive_thr  <= pwdata[POS_W-1:0];
                REG_PROP_GAIN:   r_prop_gain   <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN:  r_deriv_gain  <= pwdata[GAIN_W-1:0];
                REG_SPEED_LIMIT: r_speed_limit <= pwdata[SPEED_W-1:0];
                default: ;      // addresses past the map are ignored
            endcase
        end
    end

    // register read, zero filled
    always_comb begin
        unique case (w_cfg_idx)
            REG_TARGET_X:    prdata = {16'd0, r_target_x};
            REG_TARGET_Y:    prdata = {16'd0, r_target_y};
            REG_ARRIVE_THR:  prdata = {16'd0, r_arrive_thr};
            REG_PROP_GAIN:   prdata = {16'd0, r_prop_gain};
            REG_DERIV_GAIN:  prdata = {16'd0, r_deriv_gain};
            REG_SPEED_LIMIT: prdata = {19'd0, r_speed_limit};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // datapath state
    // ------------------------------------------------------------------------
    t_state               r_state;
    logic [POS_W-1:0]     r_dx_mag;     // |target - robot| fits 16 bits
    logic [POS_W-1:0]     r_dy_mag;
    logic                 r_dx_neg;
    logic                 r_dy_neg;
    logic [PROD_W-1:0]    r_acc;        // parked product
    logic [DIST_W-1:0]    r_dist;
    logic [DIST_W-1:0]    r_last_dist;
    logic                 r_reached;
    logic [SPEED_W-1:0]   r_speed;
    logic [SPEED_W-1:0]   r_qx;
    logic [SPEED_W-1:0]   r_qy;
    logic                 r_out_valid;
    logic [VEL_W-1:0]     r_out_vx;
    logic [VEL_W-1:0]     r_out_vy;
    logic [DIST_W-1:0]    r_out_dist;
    logic                 r_out_arrived;

    // input deltas, 17-bit signed
    logic signed [POS_W:0] w_dx;
    logic signed [POS_W:0] w_dy;
    logic        [POS_W:0] w_dx_abs;
    logic        [POS_W:0] w_dy_abs;

    assign w_dx     = $signed({r_target_x[POS_W-1], r_target_x})
                    - $signed({s_axis_tdata[POS_W-1], s_axis_tdata[POS_W-1:0]});
    assign w_dy     = $signed({r_target_y[POS_W-1], r_target_y})
                    - $signed({s_axis_tdata[2*POS_W-1], s_axis_tdata[2*POS_W-1:POS_W]});
    assign w_dx_abs = w_dx[POS_W] ? (POS_W+1)'(-w_dx) : w_dx;
    assign w_dy_abs = w_dy[POS_W] ? (POS_W+1)'(-w_dy) : w_dy;

    // shared multiplier and its operand select
    logic [MAG_W-1:0]  w_mul_a;
    logic [MAG_W-1:0]  w_mul_b;
    logic [PROD_W-1:0] w_prod;

    // distance change for the derivative term
    logic [DIST_W:0]   w_diff;
    logic              w_diff_neg;
    logic [DIST_W-1:0] w_diff_mag;

    assign w_diff     = {1'b0, r_dist} - {1'b0, r_last_dist};
    assign w_diff_neg = w_diff[DIST_W];
    assign w_diff_mag = w_diff_neg ? DIST_W'(-w_diff) : w_diff[DIST_W-1:0];

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_SQX: begin
                w_mul_a = {1'b0, r_dx_mag};
                w_mul_b = {1'b0, r_dx_mag};
            end
            S_SQY: begin
                w_mul_a = {1'b0, r_dy_mag};
                w_mul_b = {1'b0, r_dy_mag};
            end
            S_KP: begin
                w_mul_a = r_dist;
                w_mul_b = {1'b0, r_prop_gain};
            end
            S_KD: begin
                w_mul_a = w_diff_mag;
                w_mul_b = {1'b0, r_deriv_gain};
            end
            S_MX: begin
                w_mul_a = {1'b0, r_dx_mag};
                w_mul_b = MAG_W'(r_speed);
            end
            S_MY: begin
                w_mul_a = {1'b0, r_dy_mag};
                w_mul_b = MAG_W'(r_speed);
            end
            default: ;
        endcase
    end

    psv_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // sum of squares stays below 2^33
    logic [PROD_W-1:0] w_d2;
    t_unit_stat        w_sq_stat;
    logic [DIST_W-1:0] w_root;

    assign w_d2 = r_acc + w_prod;

    psv_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_SUM),
        .i_radicand (SQ_IN_W'(w_d2)),
        .o_stat     (w_sq_stat),
        .o_root     (w_root)
    );

    // pd sum in 2^-20 m/s, the kd term carries the sign of the change
    logic signed [PROD_W+1:0] w_pd;
    logic        [PROD_W-10:0] w_pd_q;
    logic        [SPEED_W-1:0] w_limit;
    logic        [SPEED_W-1:0] w_speed;

    assign w_pd    = w_diff_neg ? $signed({2'b00, r_acc}) - $signed({2'b00, w_prod})
                                : $signed({2'b00, r_acc}) + $signed({2'b00, w_prod});
    assign w_pd_q  = w_pd[PROD_W:10];
    assign w_limit = (r_speed_limit > SPEED_CAP) ? SPEED_CAP : r_speed_limit;

    always_comb begin
        if (w_pd[PROD_W+1] || (w_pd == '0)) begin
            w_speed = '0;
        end else if (w_pd_q > (PROD_W-9)'(w_limit)) begin
            w_speed = w_limit;
        end else begin
            w_speed = w_pd_q[SPEED_W-1:0];
        end
    end

    // shared divider for both components
    t_unit_stat           w_div_stat;
    logic [DIV_NUM_W-1:0] w_quot;

    psv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_DX) || (r_state == S_DY)),
        .i_num   (w_prod[DIV_NUM_W-1:0]),
        .i_den   (r_dist),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    logic w_in_acc;
    logic w_out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_dist <= '0;
            r_reached   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result loaded in the same cycle keeps it set
            if (r_out_valid && m_axis_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_dx_mag <= w_dx_abs[POS_W-1:0];
                        r_dy_mag <= w_dy_abs[POS_W-1:0];
                        r_dx_neg <= w_dx[POS_W];
                        r_dy_neg <= w_dy[POS_W];
                        // start of a new goal
                        if (s_axis_tuser) begin
                            r_last_dist <= '0;
                            r_reached   <= 1'b0;
                        end
                        r_state <= S_SQX;
                    end
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: begin
                    r_acc   <= w_prod;
                    r_state <= S_SUM;
                end
                S_SUM: r_state <= S_SQRT;
                S_SQRT: begin
                    if (w_sq_stat.done) begin
                        r_dist  <= w_root;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_qx <= '0;
                    r_qy <= '0;
                    if (r_reached) begin
                        r_state <= S_OUT;
                    end else if (r_dist < {1'b0, r_arrive_thr}) begin
                        r_reached <= 1'b1;
                        r_state   <= S_OUT;
                    end else begin
                        r_state <= S_KP;
                    end
                end
                S_KP: r_state <= S_KD;
                S_KD: begin
                    r_acc   <= w_prod;
                    r_state <= S_SPD;
                end
                S_SPD: begin
                    r_speed     <= w_speed;
                    r_last_dist <= r_dist;
                    // zero distance leaves no direction, velocity stays zero
                    r_state     <= (r_dist == '0) ? S_OUT : S_MX;
                end
                S_MX: r_state <= S_DX;
                S_DX: r_state <= S_DIVX;
                S_DIVX: begin
                    if (w_div_stat.done) begin
                        r_qx    <= w_quot[SPEED_W-1:0];
                        r_state <= S_MY;
                    end
                end
                S_MY: r_state <= S_DY;
                S_DY: r_state <= S_DIVY;
                S_DIVY: begin
                    if (w_div_stat.done) begin
                        r_qy    <= w_quot[SPEED_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_vx      <= r_dx_neg ? VEL_W'(-{1'b0, r_qx}) : {1'b0, r_qx};
                        r_out_vy      <= r_dy_neg ? VEL_W'(-{1'b0, r_qy}) : {1'b0, r_qy};
                        r_out_dist    <= r_dist;
                        r_out_arrived <= r_reached;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_dist, r_out_vy, r_out_vx};
    assign m_axis_tuser  = r_out_arrived;

`ifndef SYNTHESIS
    // an arrived result never commands motion
    a_arrived_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[27:0] == '0))
        else $error("velocity nonzero on an arrived result");

    // an accepted word closes the input until its result is handed over
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !s_axis_tready)
        else $error("input reopened right after accept");

    // the speed never passes the hard cap
    a_speed_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MX) |-> (r_speed <= SPEED_CAP))
        else $error("speed above cap");

    // root result arrives only while the sequencer waits for it
    a_root_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_stat.done |-> (r_state == S_SQRT))
        else $error("square root done outside its wait state");

    // quotients arrive only while a division is awaited
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> ((r_state == S_DIVX) || (r_state == S_DIVY)))
        else $error("division done outside its wait state");
`endif

endmodule

/* bench/tb_point_seek_pd_velocity.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_seek_pd_velocity
// self-checking bench for the go-to-point pd velocity block: a directed
// table of corner cases, then phases of random goal approaches under
// changing register settings, each result checked against the table's own value
// or a local model of the distance, pd speed, clamp and velocity split
// ----------------------------------------------------------------------------
module tb_point_seek_pd_velocity;
    import psv_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_WORDS    = 148;
    localparam int TAIL_CYCLES    = 200;

    // one result word, split into its fields
    typedef struct packed {
        logic [VEL_W-1:0]  vel_x;
        logic [VEL_W-1:0]  vel_y;
        logic [DIST_W-1:0] distance;
        logic              arrived;
    } t_motion;

    // directed table: a row is either a register write or an input word
    typedef enum logic {
        ROW_WRITE,
        ROW_WORD
    } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_reg_idx          reg_idx;
        logic [15:0]       value;
        logic [POS_W-1:0]  rx;
        logic [POS_W-1:0]  ry;
        logic              first;
        bit                typed;     // expected result written in the row
        t_motion           want;
    } t_script_row;

    // clock and reset
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    // apb side
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // streams
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    // register mirror used by the motion model
    logic signed [POS_W-1:0]   cfg_tx   = '0;
    logic signed [POS_W-1:0]   cfg_ty   = '0;
    logic [GAIN_W-1:0]         cfg_thr  = 16'd100;
    logic [GAIN_W-1:0]         cfg_kp   = 16'd1573;
    logic [GAIN_W-1:0]         cfg_kd   = 16'd315;
    logic [SPEED_W-1:0]        cfg_vmax = 13'd1024;

    // model state: distance of the last moving step and the sticky arrival
    logic [DIST_W-1:0] held_distance = '0;
    bit                goal_reached  = 1'b0;

    t_motion     expected_motion[$];
    t_script_row script[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int gap_pct        = 20;     // chance of a sender gap before a word
    int stall_pct      = 10;     // chance per cycle of a receiver stall burst
    int stall_left     = 0;

    point_seek_pd_velocity dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // motion model
    // ------------------------------------------------------------------

    // integer square root, one result bit per trial from the top
    function automatic logic [DIST_W-1:0] floor_root(longint unsigned n);
        logic [DIST_W-1:0] root;
        longint unsigned   trial;
        root = '0;
        for (int i = DIST_W - 1; i >= 0; i--) begin
            trial = longint'(root | (17'd1 << i));
            if (trial * trial <= n)
                root = root | (17'd1 << i);
        end
        return root;
    endfunction

    // share of the speed along one axis, truncated toward zero
    function automatic longint axis_share(longint speed, longint delta, longint span);
        longint mag;
        longint q;
        mag = (delta < 0) ? -delta : delta;
        q   = (speed * mag) / span;
        return (delta < 0) ? -q : q;
    endfunction

    // next result word for one accepted position, updates the model state
    function automatic t_motion predict_motion(logic signed [POS_W-1:0] rx,
                                               logic signed [POS_W-1:0] ry,
                                               logic first);
        longint          dx;
        longint          dy;
        longint          span;
        longint          s;
        longint          limit;
        longint          speed;
        longint          vx;
        longint          vy;
        longint unsigned sq;
        t_motion         r;
        dx   = longint'(cfg_tx) - longint'(rx);
        dy   = longint'(cfg_ty) - longint'(ry);
        sq   = dx * dx + dy * dy;
        span = longint'(floor_root(sq));
        vx   = 0;
        vy   = 0;
        // a new goal forgets the old distance and the arrival
        if (first) begin
            held_distance = '0;
            goal_reached  = 1'b0;
        end
        if (!goal_reached) begin
            if (span < longint'(cfg_thr)) begin
                goal_reached = 1'b1;
            end else begin
                // pd sum in 2^-20 m/s, derivative against the last moving step
                s = longint'(cfg_kp) * span
                  + longint'(cfg_kd) * (span - longint'(held_distance));
                limit = (cfg_vmax > SPEED_CAP) ? longint'(SPEED_CAP) : longint'(cfg_vmax);
                speed = 0;
                if (s > 0)
                    speed = ((s >>> 10) > limit) ? limit : (s >>> 10);
                if (span != 0) begin
                    vx = axis_share(speed, dx, span);
                    vy = axis_share(speed, dy, span);
                end
                held_distance = span[DIST_W-1:0];
            end
        end
        r.vel_x    = vx[VEL_W-1:0];
        r.vel_y    = vy[VEL_W-1:0];
        r.distance = span[DIST_W-1:0];
        r.arrived  = goal_reached;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // directed table helpers
    // ------------------------------------------------------------------

    function automatic void add_write(t_reg_idx idx, int v);
        t_script_row row;
        row         = '{kind: ROW_WRITE, reg_idx: REG_TARGET_X, default: '0};
        row.reg_idx = idx;
        row.value   = v[15:0];
        script.push_back(row);
    endfunction

    function automatic void add_word(int rx, int ry, bit first);
        t_script_row row;
        row       = '{kind: ROW_WORD, reg_idx: REG_TARGET_X, default: '0};
        row.rx    = rx[15:0];
        row.ry    = ry[15:0];
        row.first = first;
        script.push_back(row);
    endfunction

    // word whose result is plain from the row itself
    function automatic void add_known(int rx, int ry, bit first,
                                      int vx, int vy, int span, bit arr);
        add_word(rx, ry, first);
        script[$].typed          = 1'b1;
        script[$].want.vel_x     = vx[VEL_W-1:0];
        script[$].want.vel_y     = vy[VEL_W-1:0];
        script[$].want.distance  = span[DIST_W-1:0];
        script[$].want.arrived   = arr;
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[POS_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // bus tasks, all entered and left on a rising edge
    // ------------------------------------------------------------------

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    // setup then access cycle, mirror follows the write
    task automatic write_reg(t_reg_idx idx, logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TARGET_X:    cfg_tx   = v;
            REG_TARGET_Y:    cfg_ty   = v;
            REG_ARRIVE_THR:  cfg_thr  = v;
            REG_PROP_GAIN:   cfg_kp   = v;
            REG_DERIV_GAIN:  cfg_kd   = v;
            REG_SPEED_LIMIT: cfg_vmax = v[SPEED_W-1:0];
            default: ;
        endcase
        // idle wait so a following write never restarts psel in this step
        @(posedge i_clk);
    endtask

    // hold the sender until every expected word has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_motion.size() != 0)
            @(posedge i_clk);
    endtask

    // offer one position word, predict its result once it is taken
    task automatic send_word(logic [POS_W-1:0] rx, logic [POS_W-1:0] ry, logic first,
                             bit typed, t_motion want);
        t_motion predicted;
        if ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15))
                @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ry, rx};
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predicted = predict_motion($signed(rx), $signed(ry), first);
        expected_motion.push_back(typed ? want : predicted);
    endtask

    // ------------------------------------------------------------------
    // result side: stall bursts and the checker
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left    <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // each taken result word against the oldest expectation
    always @(posedge i_clk) begin
        t_motion got;
        t_motion want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.vel_x    = m_axis_tdata[13:0];
            got.vel_y    = m_axis_tdata[27:14];
            got.distance = m_axis_tdata[44:28];
            got.arrived  = m_axis_tuser;
            if (expected_motion.size() == 0) begin
                note_mismatch($sformatf("unexpected word: vx %0d vy %0d dist %0d arr %0d",
                    $signed(got.vel_x), $signed(got.vel_y), got.distance, got.arrived));
            end else begin
                want = expected_motion.pop_front();
                if (got.vel_x !== want.vel_x || got.vel_y !== want.vel_y ||
                    got.distance !== want.distance || got.arrived !== want.arrived)
                    note_mismatch($sformatf({"mismatch: want vx %0d vy %0d dist %0d arr %0d,",
                                             " got vx %0d vy %0d dist %0d arr %0d"},
                        $signed(want.vel_x), $signed(want.vel_y), want.distance, want.arrived,
                        $signed(got.vel_x), $signed(got.vel_y), got.distance, got.arrived));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin
        longint  sx;
        longint  sy;
        longint  px;
        longint  py;
        int      n;
        int      sent;
        int      sel;
        t_motion none;

        none = '0;

        // reset settings: target at origin, threshold 100
        add_known(0, 0, 1, 0, 0, 0, 1);                 // on target right after reset
        add_known(-32768, -32768, 0, 0, 0, 46340, 1);   // already reached, distance still out
        add_word(32767, 32767, 1);                      // new goal far away, speed clamps
        add_word(32767, 32767, 0);                      // same distance, no derivative
        add_word(1000, 0, 0);                           // closing in, negative derivative
        add_known(50, 50, 0, 0, 0, 70, 1);              // arriving step
        add_known(-30000, 20000, 0, 0, 0, 36055, 1);    // sticky after arrival
        add_word(-100, 0, 1);                           // distance equal to threshold moves
        add_known(0, -99, 0, 0, 0, 99, 1);              // just under threshold
        // zero threshold: robot on target keeps moving state
        add_write(REG_ARRIVE_THR, 0);
        add_known(0, 0, 1, 0, 0, 0, 0);                 // zero distance while moving
        add_word(1, 0, 0);                              // unit distance
        // largest gains, far corners, limit above the cap saturates
        add_write(REG_TARGET_X, 32767);
        add_write(REG_TARGET_Y, -32768);
        add_write(REG_PROP_GAIN, 65535);
        add_write(REG_DERIV_GAIN, 65535);
        add_write(REG_SPEED_LIMIT, 8191);
        add_word(-32768, 32767, 1);                     // largest distance
        add_word(-32768, 32767, 0);
        add_known(32767, -32768, 0, 0, 0, 0, 0);        // on target, pd sum negative
        // zero gains and zero limit
        add_write(REG_SPEED_LIMIT, 4096);
        add_write(REG_PROP_GAIN, 0);
        add_write(REG_DERIV_GAIN, 0);
        add_word(0, 0, 1);
        add_write(REG_PROP_GAIN, 1);
        add_write(REG_SPEED_LIMIT, 0);
        add_word(0, 0, 1);
        // derivative only: positive then negative change
        add_write(REG_SPEED_LIMIT, 4096);
        add_write(REG_PROP_GAIN, 0);
        add_write(REG_DERIV_GAIN, 65535);
        add_word(0, 0, 1);
        add_word(100, -100, 0);
        // largest threshold
        add_write(REG_ARRIVE_THR, 65535);
        add_known(0, 0, 1, 0, 0, 46340, 1);
        // back to reset settings
        add_write(REG_TARGET_X, 0);
        add_write(REG_TARGET_Y, 0);
        add_write(REG_ARRIVE_THR, 100);
        add_write(REG_PROP_GAIN, 1573);
        add_write(REG_DERIV_GAIN, 315);
        add_write(REG_SPEED_LIMIT, 1024);
        add_known(-1, -1, 1, 0, 0, 1, 1);
        add_word(300, -400, 1);
        add_word(-300, 400, 0);

        repeat (2)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(script[i].reg_idx, script[i].value);
            end else begin
                send_word(script[i].rx, script[i].ry, script[i].first,
                          script[i].typed, script[i].want);
            end
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    // gains and speed limit at their top end, far corner target, zero threshold
                    write_reg(REG_TARGET_X, 16'h7FFF);
                    write_reg(REG_TARGET_Y, 16'h8000);
                    write_reg(REG_ARRIVE_THR, 16'd0);
                    write_reg(REG_PROP_GAIN, 16'hFFFF);
                    write_reg(REG_DERIV_GAIN, 16'hFFFF);
                    write_reg(REG_SPEED_LIMIT, 16'd8191);
                end
                1: begin
                    // opposite corner, no gain, no speed, huge threshold
                    write_reg(REG_TARGET_X, 16'h8000);
                    write_reg(REG_TARGET_Y, 16'h7FFF);
                    write_reg(REG_ARRIVE_THR, 16'hFFFF);
                    write_reg(REG_PROP_GAIN, 16'd0);
                    write_reg(REG_DERIV_GAIN, 16'd0);
                    write_reg(REG_SPEED_LIMIT, 16'd0);
                end
                2: begin
                    write_reg(REG_TARGET_X, 16'd0);
                    write_reg(REG_TARGET_Y, 16'd0);
                    write_reg(REG_ARRIVE_THR, 16'd100);
                    write_reg(REG_PROP_GAIN, 16'd1573);
                    write_reg(REG_DERIV_GAIN, 16'd315);
                    write_reg(REG_SPEED_LIMIT, 16'd1024);
                end
                default: begin
                    write_reg(REG_TARGET_X, 16'($urandom));
                    write_reg(REG_TARGET_Y, 16'($urandom));
                    write_reg(REG_ARRIVE_THR, ($urandom_range(0, 3) == 0) ?
                              16'($urandom) : 16'($urandom_range(0, 3000)));
                    write_reg(REG_PROP_GAIN, 16'($urandom));
                    write_reg(REG_DERIV_GAIN, 16'($urandom));
                    write_reg(REG_SPEED_LIMIT, 16'($urandom_range(0, 8191)));
                end
            endcase

            // idling level per phase, none at all in the last one
            if (phase == RANDOM_PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                sel       = $urandom_range(0, 2);
                gap_pct   = (sel == 0) ? 0 : (sel == 1) ? 15 : 50;
                stall_pct = (sel == 0) ? 0 : (sel == 1) ? 5 : 20;
            end

            sent = 0;
            while (sent < PHASE_WORDS) begin
                // now and then let the block drain completely
                if (phase != RANDOM_PHASES - 1 && $urandom_range(0, 19) == 0)
                    wait_drained();
                n = $urandom_range(2, 30);
                // goal start: anywhere, or somewhere near the target
                if ($urandom_range(0, 1) == 1) begin
                    sx = longint'($signed(16'($urandom)));
                    sy = longint'($signed(16'($urandom)));
                end else begin
                    sx = longint'(cfg_tx) + longint'($urandom_range(0, 4000)) - 2000;
                    sy = longint'(cfg_ty) + longint'($urandom_range(0, 4000)) - 2000;
                end
                // straight approach with jitter, ending near the target
                for (int k = 0; k < n && sent < PHASE_WORDS; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        send_word(16'($urandom), 16'($urandom), 1'($urandom), 1'b0, none);
                    end else begin
                        px = sx + (longint'(cfg_tx) - sx) * k / (n - 1)
                           + longint'($urandom_range(0, 40)) - 20;
                        py = sy + (longint'(cfg_ty) - sy) * k / (n - 1)
                           + longint'($urandom_range(0, 40)) - 20;
                        send_word(clamp_pos(px), clamp_pos(py), k == 0, 1'b0, none);
                    end
                    sent++;
                end
            end
        end

        // drain, then let the block sit idle before the final check
        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge i_clk);
        if (expected_motion.size() != 0)
            note_mismatch($sformatf("%0d expected words never came",
                                    expected_motion.size()));

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
